@@ hw/rtl/sil_pkg.sv @@
package sil_pkg;

  // Fixed field widths of the command and result beats.
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned STATUS_W = 2;

  // Default capacity of the store.
  localparam int unsigned DEPTH_DEFAULT = 32;

  // Command mode codes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DUMP   = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DUMPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    insert;      // shift the new value into the sorted cells
    logic    emit_status; // send a single status-only result
    status_e code;        // status for emit_status
    logic    idx_clear;   // rewind the dump read index
    logic    dump_step;   // send the cell at the read index and advance
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic dump_last;
  } sts_t;

endpackage

@@ hw/rtl/sil_ctrl.sv @@
module sil_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          mode_i,
  input  sil_pkg::sts_t sts_i,
  output sil_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import sil_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q == S_DUMP);

  // Decode the accepted beat into datapath commands.
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.code        = ST_INSERTED;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_INSERT) begin
            cmd_o.insert      = !sts_i.full;
            cmd_o.emit_status = 1'b1;
            cmd_o.code        = sts_i.full ? ST_FULL : ST_INSERTED;
          end else if (sts_i.empty) begin
            cmd_o.emit_status = 1'b1;
            cmd_o.code        = ST_EMPTY;
          end else begin
            cmd_o.idx_clear = 1'b1;
            state_d         = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        cmd_o.dump_step = 1'b1;
        if (sts_i.dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The state register always has exactly one bit set (one-hot).
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

  // A dump is only entered with something to send.
  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !sts_i.empty)
    else $error("dump running on an empty store");

  // The last dump beat returns the controller to idle.
  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && sts_i.dump_last) |=> !busy_o)
    else $error("dump did not end after its last beat");

endmodule

@@ hw/rtl/sil_datapath.sv @@
module sil_datapath #(
  parameter int unsigned DEPTH = sil_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sil_pkg::cmd_t                      cmd_i,
  input  logic signed [sil_pkg::ITEM_W-1:0]  value_i,
  output sil_pkg::sts_t                      sts_o,
  output logic                               valid_o,
  output logic [sil_pkg::STATUS_W-1:0]       status_o,
  output logic signed [sil_pkg::ITEM_W-1:0]  item_value_o,
  output logic [sil_pkg::COUNT_W-1:0]        item_count_o,
  output logic                               last_o
);
  import sil_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic signed [ITEM_W-1:0] cells_q [DEPTH];
  logic signed [ITEM_W-1:0] cells_d [DEPTH];
  logic [DEPTH-1:0]         lt;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         idx_q, idx_d;

  logic                     valid_q, valid_d;
  logic [STATUS_W-1:0]      status_q, status_d;
  logic signed [ITEM_W-1:0] value_q, value_d;
  logic [COUNT_W-1:0]       ocount_q, ocount_d;
  logic                     last_q, last_d;

  // Each occupied cell flags whether it holds a value smaller than the new one.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count_q) && (cells_q[i] < value_i);
    end
  end

  // Compare-cell chain: keep, take the new value, or take the left neighbor.
  always_comb begin
    cells_d = cells_q;
    if (cmd_i.insert) begin
      if (!lt[0]) begin
        cells_d[0] = value_i;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (!lt[i]) begin
          cells_d[i] = lt[i-1] ? value_i : cells_q[i-1];
        end
      end
    end
  end

  assign count_d = cmd_i.insert ? count_q + CNT_W'(1) : count_q;

  assign sts_o.full      = (count_q == CNT_W'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.dump_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  // Dump read index.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clear) begin
      idx_d = '0;
    end else if (cmd_i.dump_step) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  // Result beat for the next cycle.
  always_comb begin
    valid_d  = cmd_i.emit_status || cmd_i.dump_step;
    status_d = cmd_i.code;
    value_d  = '0;
    ocount_d = COUNT_W'(count_d);
    last_d   = 1'b1;
    if (cmd_i.dump_step) begin
      status_d = ST_DUMPED;
      value_d  = cells_q[idx_q];
      last_d   = sts_o.dump_last;
    end
  end

  // Sorted cells and result payload.
  always_ff @(posedge clk_i) begin
    cells_q  <= cells_d;
    status_q <= status_d;
    value_q  <= value_d;
    ocount_q <= ocount_d;
    last_q   <= last_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign item_value_o = value_q;
  assign item_count_o = ocount_q;
  assign last_o       = last_q;

  // The store never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("store count above capacity");

  // A dump only reads occupied cells.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dump_step |-> (CNT_W'(idx_q) < count_q))
    else $error("dump index past the stored values");

  // An insert grows the store by exactly one.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the store by one");

endmodule

@@ hw/rtl/sorted_insert_list_unit.sv @@
// Sorted insertion list: a store of up to DEPTH signed 32-bit values kept in
// ascending order.
// Command channel: a beat is taken at a rising edge with start_i high and
// busy_o low. mode_i selects insert (0) or dump (1); value_i is the number
// to insert. An insert places the value before the first stored value that
// is not smaller and answers with one result in the next cycle (status
// inserted, or full when the store already holds DEPTH values). A new
// command can follow an insert in the very next cycle.
// A dump of n stored values sends n results back to back in ascending order
// with last_o on the final one; the first appears once the state register
// has entered the dump state and the result registers have taken cell 0.
// busy_o rises in the cycle after the command and stays high while the
// cells are sent; the next command can be taken in the cycle that carries
// the last dump beat. The single cell read port gives one value per cycle.
// A dump of an empty store gives one empty-status result in the next cycle.
// Result channel: valid_o marks each beat for one cycle; there is no back
// pressure, the receiver takes every beat as it comes.
// Reset empties the store; no result is pending after reset.
module sorted_insert_list_unit #(
  parameter int unsigned DEPTH = sil_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               mode_i,
  input  logic signed [sil_pkg::ITEM_W-1:0]  value_i,
  output logic                               valid_o,
  output logic [sil_pkg::STATUS_W-1:0]       status_o,
  output logic signed [sil_pkg::ITEM_W-1:0]  item_value_o,
  output logic [sil_pkg::COUNT_W-1:0]        item_count_o,
  output logic                               last_o
);
  import sil_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sil_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  sil_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (value_i),
    .sts_o        (sts),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .item_value_o (item_value_o),
    .item_count_o (item_count_o),
    .last_o       (last_o)
  );

endmodule
